// File: rtl/core/vcfd_pkg.sv
// Shared types and constants for the video capture frame DMA.
// Holds field widths, result kinds, register indexes and the store command format.
// No dependencies.
package vcfd_pkg;

    localparam int COL_W    = 13;
    localparam int LINE_W   = 12;
    localparam int DIM_W    = 13;
    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int PIX_W    = 8;
    localparam int PROD_W   = DIM_W + LINE_W;

    // Input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ARM    = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WORD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IRQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Command queue between front and store engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic              err;
        logic              burst;
        logic              irq;
        logic [ADDR_W-1:0] base;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
    } store_cmd_t;

endpackage

// File: rtl/core/vcfd_cmd_queue.sv
// Short command queue between the capture front and the store engine.
// Depends on vcfd_pkg for the command type and queue depth.
module vcfd_cmd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vcfd_pkg::store_cmd_t  in_cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vcfd_pkg::store_cmd_t  out_cmd
);
    import vcfd_pkg::*;

    store_cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  push;
    logic                  pop;

    assign in_ready  = (count_reg < (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: rtl/core/vcfd_front.sv
// Capture front: follows the syncs, queues pixels, takes arms and decides bursts.
// Depends on vcfd_pkg; feeds vcfd_cmd_queue and the byte buffer in vcfd_store.
module vcfd_front #(
    parameter int FIFO_DEPTH = 256,
    parameter int PACK_BYTES = 16,
    parameter int PHYS_AW    = 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic                          s_line_active,
    input  logic                          s_frame_active,
    input  logic [vcfd_pkg::PIX_W-1:0]    s_pixel,
    input  logic [vcfd_pkg::ADDR_W-1:0]   s_buffer_address,
    input  logic [vcfd_pkg::DIM_W-1:0]    frame_width,
    input  logic [vcfd_pkg::DIM_W-1:0]    frame_height,
    input  logic                          q_ready,
    output logic                          q_valid,
    output vcfd_pkg::store_cmd_t          q_cmd,
    output logic                          push_en,
    output logic [PHYS_AW-1:0]            push_addr,
    output logic [vcfd_pkg::PIX_W-1:0]    push_byte,
    input  logic                          rel_word
);
    import vcfd_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [COL_W-1:0]   cap_col_reg, cap_col_next;
    logic [LINE_W-1:0]  cap_line_reg, cap_line_next;
    logic               cap_en_reg, cap_en_next;
    logic               ever_armed_reg, ever_armed_next;
    logic [CNT_W-1:0]   fifo_count_reg, fifo_count_next;
    logic [COL_W-1:0]   st_col_reg, st_col_next;
    logic [LINE_W-1:0]  st_line_reg, st_line_next;
    logic [ADDR_W-1:0]  frame_base_reg, frame_base_next;
    logic               storing_reg, storing_next;
    logic [ADDR_W-1:0]  pending_base_reg, pending_base_next;
    logic               arm_pending_reg, arm_pending_next;
    logic [PHYS_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PHYS_AW:0]   phys_used_reg, phys_used_next;

    logic               accept;
    logic               push;
    logic               err;
    logic               burst;
    logic               irq;
    logic [CNT_W-1:0]   count_mid;
    logic               storing_mid;
    logic [ADDR_W-1:0]  base_mid;
    logic [COL_W-1:0]   scol_mid;
    logic [LINE_W-1:0]  sline_mid;
    logic [COL_W:0]     col_sum;
    logic [DIM_W-1:0]   line_inc;

    // Stall on a full queue or a full physical byte buffer
    assign s_ready = q_ready && !phys_used_reg[PHYS_AW];
    assign accept  = s_valid && s_ready;

    // Capture side: arm latch, sync tracking and pixel push
    always_comb begin
        cap_col_next      = cap_col_reg;
        cap_line_next     = cap_line_reg;
        cap_en_next       = cap_en_reg;
        pending_base_next = pending_base_reg;
        arm_pending_next  = arm_pending_reg;
        ever_armed_next   = ever_armed_reg;
        push              = 1'b0;
        err               = 1'b0;
        if (accept) begin
            if (s_opcode == OP_ARM) begin
                pending_base_next = s_buffer_address;
                arm_pending_next  = 1'b1;
            end else if (s_line_active && s_frame_active) begin
                if (cap_col_reg < frame_width && {1'b0, cap_line_reg} < frame_height) begin
                    push         = cap_en_reg && (fifo_count_reg < CNT_W'(FIFO_DEPTH));
                    cap_col_next = cap_col_reg + 1'b1;
                end else begin
                    err = 1'b1;
                end
            end else if (s_frame_active) begin
                if (cap_col_reg == frame_width) begin
                    cap_col_next  = '0;
                    cap_line_next = cap_line_reg + 1'b1;
                end
            end else begin
                if (cap_col_reg == frame_width &&
                    ({1'b0, cap_line_reg} + 1'b1) == frame_height) begin
                    cap_col_next  = '0;
                    cap_line_next = '0;
                    if (ever_armed_reg) begin
                        cap_en_next = 1'b1;
                    end
                end
            end
        end
        count_mid = fifo_count_reg + CNT_W'(push);

        // Take a pending arm when idle
        storing_mid = storing_reg;
        base_mid    = frame_base_reg;
        scol_mid    = st_col_reg;
        sline_mid   = st_line_reg;
        if (accept && !storing_reg && arm_pending_next) begin
            storing_mid      = 1'b1;
            base_mid         = pending_base_next;
            scol_mid         = '0;
            sline_mid        = '0;
            arm_pending_next = 1'b0;
            ever_armed_next  = 1'b1;
        end

        // Fire a burst once a pack is queued
        burst           = accept && storing_mid && (count_mid >= CNT_W'(PACK_BYTES));
        fifo_count_next = burst ? count_mid - CNT_W'(PACK_BYTES) : count_mid;
        col_sum         = {1'b0, scol_mid} + (COL_W+1)'(PACK_BYTES);
        line_inc        = {1'b0, sline_mid} + 1'b1;
        irq             = 1'b0;
        st_col_next     = scol_mid;
        st_line_next    = sline_mid;
        storing_next    = storing_mid;
        frame_base_next = base_mid;
        if (burst) begin
            if (col_sum == {1'b0, frame_width}) begin
                st_col_next  = '0;
                st_line_next = line_inc[LINE_W-1:0];
                if (line_inc == frame_height) begin
                    storing_next = 1'b0;
                    irq          = 1'b1;
                end
            end else begin
                st_col_next = col_sum[COL_W-1:0];
            end
        end
    end

    // Queue a command when the item makes any result
    assign q_valid        = err || burst || irq;
    assign q_cmd.err      = err;
    assign q_cmd.burst    = burst;
    assign q_cmd.irq      = irq;
    assign q_cmd.base     = base_mid;
    assign q_cmd.line     = sline_mid;
    assign q_cmd.column   = scol_mid;

    // Byte buffer write side
    assign push_en   = push;
    assign push_addr = wr_ptr_reg;
    assign push_byte = s_pixel;

    always_comb begin
        wr_ptr_next    = wr_ptr_reg + PHYS_AW'(push);
        phys_used_next = phys_used_reg + (PHYS_AW+1)'(push)
                       - (rel_word ? (PHYS_AW+1)'(4) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_col_reg      <= '0;
            cap_line_reg     <= '0;
            cap_en_reg       <= 1'b0;
            ever_armed_reg   <= 1'b0;
            fifo_count_reg   <= '0;
            st_col_reg       <= '0;
            st_line_reg      <= '0;
            frame_base_reg   <= '0;
            storing_reg      <= 1'b0;
            pending_base_reg <= '0;
            arm_pending_reg  <= 1'b0;
            wr_ptr_reg       <= '0;
            phys_used_reg    <= '0;
        end else begin
            cap_col_reg      <= cap_col_next;
            cap_line_reg     <= cap_line_next;
            cap_en_reg       <= cap_en_next;
            ever_armed_reg   <= ever_armed_next;
            fifo_count_reg   <= fifo_count_next;
            st_col_reg       <= st_col_next;
            st_line_reg      <= st_line_next;
            frame_base_reg   <= frame_base_next;
            storing_reg      <= storing_next;
            pending_base_reg <= pending_base_next;
            arm_pending_reg  <= arm_pending_next;
            wr_ptr_reg       <= wr_ptr_next;
            phys_used_reg    <= phys_used_next;
        end
    end

endmodule

// File: rtl/core/vcfd_store.sv
// Store engine: byte buffer, burst sequencer and the result output register.
// Depends on vcfd_pkg; takes commands from vcfd_cmd_queue and bytes from vcfd_front.
module vcfd_store #(
    parameter int PACK_BYTES = 16,
    parameter int PHYS_AW    = 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [vcfd_pkg::DIM_W-1:0]    frame_width,
    input  logic                          push_en,
    input  logic [PHYS_AW-1:0]            push_addr,
    input  logic [vcfd_pkg::PIX_W-1:0]    push_byte,
    output logic                          rel_word,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  vcfd_pkg::store_cmd_t          q_cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vcfd_pkg::KIND_W-1:0]   m_kind,
    output logic [vcfd_pkg::ADDR_W-1:0]   m_address,
    output logic [vcfd_pkg::DATA_W-1:0]   m_data,
    output logic                          m_last
);
    import vcfd_pkg::*;

    localparam int WORDS     = PACK_BYTES / 4;
    localparam int WL_W      = $clog2(WORDS + 1);
    localparam int WA_W      = PHYS_AW - 2;
    localparam int MEM_WORDS = 2 ** WA_W;

    // Sequencer stage
    logic               a_valid_reg, a_valid_next;
    logic               err_pend_reg, err_pend_next;
    logic [WL_W-1:0]    words_left_reg, words_left_next;
    logic               irq_pend_reg, irq_pend_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [WA_W-1:0]    rp_reg, rp_next;

    // Read and multiply stage
    logic               b_valid_reg, b_valid_next;
    logic [KIND_W-1:0]  b_kind_reg;
    logic               b_last_reg;
    logic [PROD_W-1:0]  b_prod_reg;
    logic [ADDR_W-1:0]  b_basecol_reg;

    // Output stage
    logic               c_valid_reg, c_valid_next;
    logic [KIND_W-1:0]  c_kind_reg;
    logic               c_last_reg;
    logic [ADDR_W-1:0]  c_address_reg;
    logic [DATA_W-1:0]  c_data_reg;

    logic [KIND_W-1:0]  slot_kind;
    logic               slot_last;
    logic               c_ready;
    logic               b_ready;
    logic               b_adv;
    logic               issue;
    logic               load;
    logic               rd_en;
    logic [DATA_W-1:0]  word_data;

    // Pick the next result slot: error first, then words, then interrupt
    always_comb begin
        if (err_pend_reg) begin
            slot_kind = KIND_ERR;
            slot_last = (words_left_reg == '0) && !irq_pend_reg;
        end else if (words_left_reg != '0) begin
            slot_kind = KIND_WORD;
            slot_last = (words_left_reg == WL_W'(1)) && !irq_pend_reg;
        end else begin
            slot_kind = KIND_IRQ;
            slot_last = 1'b1;
        end
    end

    assign c_ready  = !c_valid_reg || m_ready;
    assign b_adv    = b_valid_reg && c_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign issue    = a_valid_reg && b_ready;
    assign q_ready  = !a_valid_reg || (issue && slot_last);
    assign load     = q_valid && q_ready;
    assign rd_en    = issue && (slot_kind == KIND_WORD);
    assign rel_word = rd_en;

    // Advance the sequencer and load the next command
    always_comb begin
        a_valid_next    = a_valid_reg;
        err_pend_next   = err_pend_reg;
        words_left_next = words_left_reg;
        irq_pend_next   = irq_pend_reg;
        base_next       = base_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        if (issue) begin
            case (slot_kind)
                KIND_ERR:  err_pend_next   = 1'b0;
                KIND_WORD: words_left_next = words_left_reg - 1'b1;
                default:   irq_pend_next   = 1'b0;
            endcase
        end
        if (load) begin
            a_valid_next    = 1'b1;
            err_pend_next   = q_cmd.err;
            words_left_next = q_cmd.burst ? WL_W'(WORDS) : '0;
            irq_pend_next   = q_cmd.irq;
            base_next       = q_cmd.base;
            line_next       = q_cmd.line;
            col_next        = q_cmd.column;
        end else if (issue && slot_last) begin
            a_valid_next = 1'b0;
        end
        rp_next = rd_en ? rp_reg + 1'b1 : rp_reg;
    end

    always_comb begin
        b_valid_next = issue ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
        c_valid_next = b_adv ? 1'b1 : (m_ready ? 1'b0 : c_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            err_pend_reg   <= 1'b0;
            words_left_reg <= '0;
            irq_pend_reg   <= 1'b0;
            rp_reg         <= '0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end else begin
            a_valid_reg    <= a_valid_next;
            err_pend_reg   <= err_pend_next;
            words_left_reg <= words_left_next;
            irq_pend_reg   <= irq_pend_next;
            rp_reg         <= rp_next;
            b_valid_reg    <= b_valid_next;
            c_valid_reg    <= c_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        line_reg <= line_next;
        col_reg  <= col_next;
        if (issue) begin
            b_kind_reg    <= slot_kind;
            b_last_reg    <= slot_last;
            b_prod_reg    <= PROD_W'(frame_width) * PROD_W'(line_reg);
            b_basecol_reg <= base_reg + ADDR_W'(col_reg);
        end
        if (b_adv) begin
            c_kind_reg    <= b_kind_reg;
            c_last_reg    <= b_last_reg;
            c_address_reg <= (b_kind_reg == KIND_WORD) ?
                             b_basecol_reg + ADDR_W'(b_prod_reg) : '0;
            c_data_reg    <= (b_kind_reg == KIND_WORD) ? word_data : '0;
        end
    end

    // Byte buffer: one lane per byte of a word, first byte in the top lane
    for (genvar ln = 0; ln < 4; ln++) begin : g_lane
        logic [PIX_W-1:0] lane_mem [MEM_WORDS];
        logic [PIX_W-1:0] lane_rd_reg;

        always_ff @(posedge aclk) begin
            if (push_en && (push_addr[1:0] == 2'(ln))) begin
                lane_mem[push_addr[PHYS_AW-1:2]] <= push_byte;
            end
            if (rd_en) begin
                lane_rd_reg <= lane_mem[rp_reg];
            end
        end

        assign word_data[DATA_W-1-PIX_W*ln -: PIX_W] = lane_rd_reg;
    end

    assign m_valid   = c_valid_reg;
    assign m_kind    = c_kind_reg;
    assign m_address = c_address_reg;
    assign m_data    = c_data_reg;
    assign m_last    = c_last_reg;

endmodule

// File: rtl/core/video_capture_frame_dma.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    opcode, line_active, frame_active, pixel, buffer_address
// m_        out  m_valid/m_ready    kind, address, data, last
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (frame_width, frame_height)
//
// One input item is taken per cycle when not stalled; results leave at one per cycle
// while m_ready is high, through an output register.
// Input stalls only when the four-entry command queue is full or the byte buffer
// (twice the capture FIFO depth, rounded to a power of two) has no free byte.
// Reset is synchronous; the byte buffer is not cleared and needs no clearing pass.
// Top level of the video capture frame DMA; depends on vcfd_pkg and all vcfd_ modules.
module video_capture_frame_dma #(
    parameter int PACK_BYTES = 16,
    parameter int FIFO_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic                              s_line_active,
    input  logic                              s_frame_active,
    input  logic [vcfd_pkg::PIX_W-1:0]        s_pixel,
    input  logic [vcfd_pkg::ADDR_W-1:0]       s_buffer_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vcfd_pkg::KIND_W-1:0]       m_kind,
    output logic [vcfd_pkg::ADDR_W-1:0]       m_address,
    output logic [vcfd_pkg::DATA_W-1:0]       m_data,
    output logic                              m_last,
    input  logic                              cfg_wr_en,
    input  logic [vcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vcfd_pkg::DIM_W-1:0]        cfg_wdata
);
    import vcfd_pkg::*;

    localparam int PHYS_AW = $clog2(FIFO_DEPTH) + 1;

    logic [DIM_W-1:0]   frame_width_reg, frame_width_next;
    logic [DIM_W-1:0]   frame_height_reg, frame_height_next;

    logic               fq_valid;
    logic               fq_ready;
    store_cmd_t         fq_cmd;
    logic               sq_valid;
    logic               sq_ready;
    store_cmd_t         sq_cmd;
    logic               push_en;
    logic [PHYS_AW-1:0] push_addr;
    logic [PIX_W-1:0]   push_byte;
    logic               rel_word;

    // Configuration registers
    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_next  = cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    vcfd_front #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PACK_BYTES (PACK_BYTES),
        .PHYS_AW    (PHYS_AW)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_line_active    (s_line_active),
        .s_frame_active   (s_frame_active),
        .s_pixel          (s_pixel),
        .s_buffer_address (s_buffer_address),
        .frame_width      (frame_width_reg),
        .frame_height     (frame_height_reg),
        .q_ready          (fq_ready),
        .q_valid          (fq_valid),
        .q_cmd            (fq_cmd),
        .push_en          (push_en),
        .push_addr        (push_addr),
        .push_byte        (push_byte),
        .rel_word         (rel_word)
    );

    vcfd_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_cmd   (sq_cmd)
    );

    vcfd_store #(
        .PACK_BYTES (PACK_BYTES),
        .PHYS_AW    (PHYS_AW)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_width (frame_width_reg),
        .push_en     (push_en),
        .push_addr   (push_addr),
        .push_byte   (push_byte),
        .rel_word    (rel_word),
        .q_valid     (sq_valid),
        .q_ready     (sq_ready),
        .q_cmd       (sq_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_address   (m_address),
        .m_data      (m_data),
        .m_last      (m_last)
    );

endmodule
